>>> hdl/rational_alu_with_reduction_macros.svh
// Assertion helpers shared by the rational ALU modules.
`ifndef RATIONAL_ALU_WITH_REDUCTION_MACROS_SVH
`define RATIONAL_ALU_WITH_REDUCTION_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RALU_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rational ALU check failed: same-cycle property");

// Consequent checked in the cycle after the antecedent.
`define RALU_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rational ALU check failed: next-cycle property");

`endif

>>> hdl/ralu_pkg.sv
`default_nettype none

package ralu_pkg;

  // Result word width; the reduced fraction must fit a signed word of this size.
  localparam int WORD_BITS = 32;

  localparam int NUM_W   = 32;
  localparam int DEN_W   = 31;
  localparam int PROD_W  = 64;
  localparam int SHIFT_W = $clog2(PROD_W);
  localparam int DIV_STEPS = PROD_W;

  localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (WORD_BITS - 1);

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [NUM_W-1:0] a_num;
    logic [DEN_W-1:0]        a_den;
    logic signed [NUM_W-1:0] b_num;
    logic [DEN_W-1:0]        b_den;
  } in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [PROD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/ralu_div.sv
`default_nettype none

`include "rational_alu_with_reduction_macros.svh"

module ralu_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ralu_pkg::div_req_t  req,
  output ralu_pkg::div_rsp_t       rsp
);

  logic                              busy;
  logic                              done;
  logic [ralu_pkg::SHIFT_W-1:0]      cnt;
  logic [ralu_pkg::PROD_W:0]         rem;
  logic [ralu_pkg::PROD_W-1:0]       quo;
  logic [ralu_pkg::PROD_W-1:0]       dsr;

  logic [ralu_pkg::PROD_W:0]         shifted;
  logic                              fits;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem[ralu_pkg::PROD_W-1:0], quo[ralu_pkg::PROD_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ralu_pkg::SHIFT_W'(ralu_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? shifted - {1'b0, dsr} : shifted;
      quo <= {quo[ralu_pkg::PROD_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

  `RALU_ASSERT_NOW(a_div_start_idle, clk, rst, req.start, !busy)
  `RALU_ASSERT_NOW(a_div_done_after_busy, clk, rst, done, $past(busy) && !busy)
  `RALU_ASSERT_NEXT(a_div_last_step, clk, rst,
                    busy && !req.start && cnt == ralu_pkg::SHIFT_W'(ralu_pkg::DIV_STEPS - 1),
                    done)

endmodule

`default_nettype wire

>>> hdl/rational_alu_with_reduction.sv
// Channel   Direction  Payload         Handshake
// in        input      ralu_pkg::in_t  in_valid / in_ready
// out       output     ralu_pkg::out_t out_valid / out_ready
//
// One transaction at a time: in_ready is high only while idle. Multiply and divide form two
// products, add and subtract three and a sum, on the shared 32x32 multiplier; then come one
// binary GCD step per cycle and two runs of the restoring divider, for the numerator and for
// the denominator. A zero denominator is answered with ST_DIV0 without the GCD or divider.
// The finished result sits in an output register, so a stalled out channel does not stop
// the next input transaction from being taken. rst is synchronous and clears all control.

`default_nettype none

`include "rational_alu_with_reduction_macros.svh"

module rational_alu_with_reduction (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ralu_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ralu_pkg::out_t       out_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL1      = 4'd1;
  localparam logic [3:0] S_MUL2      = 4'd2;
  localparam logic [3:0] S_MUL3      = 4'd3;
  localparam logic [3:0] S_ADD       = 4'd4;
  localparam logic [3:0] S_CHECK     = 4'd5;
  localparam logic [3:0] S_GCD       = 4'd6;
  localparam logic [3:0] S_SCALE     = 4'd7;
  localparam logic [3:0] S_DIVN_GO   = 4'd8;
  localparam logic [3:0] S_DIVN_WAIT = 4'd9;
  localparam logic [3:0] S_DIVD_GO   = 4'd10;
  localparam logic [3:0] S_DIVD_WAIT = 4'd11;
  localparam logic [3:0] S_RANGE     = 4'd12;
  localparam logic [3:0] S_FINISH    = 4'd13;

  logic [3:0]                         st;
  ralu_pkg::in_t                      opnd;
  logic signed [ralu_pkg::PROD_W-1:0] acc;
  logic signed [ralu_pkg::PROD_W-1:0] prod;
  logic signed [ralu_pkg::PROD_W-1:0] rd;
  logic [ralu_pkg::PROD_W-1:0]        nmag;
  logic [ralu_pkg::PROD_W-1:0]        dmag;
  logic                               neg;
  logic [ralu_pkg::PROD_W-1:0]        u;
  logic [ralu_pkg::PROD_W-1:0]        v;
  logic [ralu_pkg::SHIFT_W-1:0]       k;
  logic [ralu_pkg::PROD_W-1:0]        g;
  logic [ralu_pkg::PROD_W-1:0]        nq;
  ralu_pkg::out_t                     fin;

  logic signed [ralu_pkg::NUM_W-1:0]  mul_a;
  logic signed [ralu_pkg::NUM_W-1:0]  mul_b;
  logic signed [ralu_pkg::PROD_W-1:0] mul_p;
  logic                               uge;
  logic [ralu_pkg::PROD_W-1:0]        diff;
  logic                               ovf;
  logic [ralu_pkg::PROD_W-1:0]        dq;
  ralu_pkg::div_req_t                 dreq;
  ralu_pkg::div_rsp_t                 drsp;

  assign in_ready = (st == S_IDLE);

  // Shared signed multiplier; the denominators are widened with a zero sign bit.
  always_comb begin
    mul_a = $signed({1'b0, opnd.a_den});
    mul_b = $signed({1'b0, opnd.b_den});
    case (st)
      S_MUL1: begin
        mul_a = opnd.a_num;
        mul_b = (opnd.action == ralu_pkg::ACT_MUL) ? opnd.b_num : $signed({1'b0, opnd.b_den});
      end
      S_MUL2: begin
        mul_b = (opnd.action == ralu_pkg::ACT_DIV) ? opnd.b_num : $signed({1'b0, opnd.b_den});
      end
      S_MUL3: begin
        mul_b = opnd.b_num;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Binary GCD step: one compare and one subtract on the larger minus the smaller.
  assign uge  = u >= v;
  assign diff = uge ? u - v : v - u;

  assign dq  = drsp.quot;
  assign ovf = (dq > ralu_pkg::LIM - 1'b1) ||
               (neg ? nq > ralu_pkg::LIM : nq > ralu_pkg::LIM - 1'b1);

  assign dreq.start    = (st == S_DIVN_GO) || (st == S_DIVD_GO);
  assign dreq.dividend = (st == S_DIVD_GO) ? dmag : nmag;
  assign dreq.divisor  = g;

  ralu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (st == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            st <= S_MUL1;
          end
        end
        S_MUL1: st <= S_MUL2;
        S_MUL2: begin
          if (opnd.action == ralu_pkg::ACT_ADD || opnd.action == ralu_pkg::ACT_SUB) begin
            st <= S_MUL3;
          end else begin
            st <= S_CHECK;
          end
        end
        S_MUL3: st <= S_ADD;
        S_ADD:  st <= S_CHECK;
        S_CHECK: begin
          st <= (rd == '0) ? S_FINISH : S_GCD;
        end
        S_GCD: begin
          if (u == '0) begin
            st <= S_SCALE;
          end
        end
        S_SCALE:   st <= S_DIVN_GO;
        S_DIVN_GO: st <= S_DIVN_WAIT;
        S_DIVN_WAIT: begin
          if (drsp.done) begin
            st <= S_DIVD_GO;
          end
        end
        S_DIVD_GO: st <= S_DIVD_WAIT;
        S_DIVD_WAIT: begin
          if (drsp.done) begin
            st <= S_RANGE;
          end
        end
        S_RANGE: st <= S_FINISH;
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        if (in_valid) begin
          opnd <= in_data;
        end
      end
      S_MUL1: acc  <= mul_p;
      S_MUL2: rd   <= mul_p;
      S_MUL3: prod <= mul_p;
      S_ADD: begin
        acc <= (opnd.action == ralu_pkg::ACT_SUB) ? acc - prod : acc + prod;
      end
      S_CHECK: begin
        nmag <= acc[ralu_pkg::PROD_W-1] ? ralu_pkg::PROD_W'(0) - acc : acc;
        dmag <= rd[ralu_pkg::PROD_W-1]  ? ralu_pkg::PROD_W'(0) - rd  : rd;
        u    <= acc[ralu_pkg::PROD_W-1] ? ralu_pkg::PROD_W'(0) - acc : acc;
        v    <= rd[ralu_pkg::PROD_W-1]  ? ralu_pkg::PROD_W'(0) - rd  : rd;
        k    <= '0;
        neg  <= (acc[ralu_pkg::PROD_W-1] != rd[ralu_pkg::PROD_W-1]) && (acc != '0);
        fin  <= '{res_num: '0, res_den: '0, status: ralu_pkg::ST_DIV0};
      end
      S_GCD: begin
        if (u != '0) begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (uge) begin
            u <= diff >> 1;
          end else begin
            v <= diff >> 1;
          end
        end
      end
      S_SCALE: g <= v << k;
      S_DIVN_WAIT: begin
        if (drsp.done) begin
          nq <= drsp.quot;
        end
      end
      S_RANGE: begin
        if (ovf) begin
          fin <= '{res_num: '0, res_den: '0, status: ralu_pkg::ST_OVF};
        end else begin
          fin.res_num <= neg ? ralu_pkg::NUM_W'(ralu_pkg::PROD_W'(0) - nq)
                             : nq[ralu_pkg::NUM_W-1:0];
          fin.res_den <= dq[ralu_pkg::DEN_W-1:0];
          fin.status  <= ralu_pkg::ST_OK;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_data <= fin;
        end
      end
      default: begin
      end
    endcase
  end

  `RALU_ASSERT_NOW(a_ok_has_den, clk, rst,
                   out_valid && out_data.status == ralu_pkg::ST_OK,
                   out_data.res_den != '0)
  `RALU_ASSERT_NOW(a_err_is_zero, clk, rst,
                   out_valid && out_data.status != ralu_pkg::ST_OK,
                   out_data.res_num == '0 && out_data.res_den == '0)
  `RALU_ASSERT_NOW(a_gcd_v_nonzero, clk, rst, st == S_GCD, v != '0)
  `RALU_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1310;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  ralu_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  ralu_pkg::out_t out_data;

  ralu_pkg::out_t expected_fractions[$];
  int   faults;
  int   quiet_cycles;
  bit   tx_idle_en;
  bit   rx_idle_en;
  int   hold_requests;
  int   hold_served;
  int   hold_left;

  rational_alu_with_reduction dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact cross products, Euclidean reduction, then the sign is moved onto the numerator.
  function automatic ralu_pkg::out_t reduce_fraction(ralu_pkg::in_t x);
    longint signed an, ad, bn, bd, top, bot;
    logic [63:0] n, d, g, r, lim;
    logic top_neg, bot_neg, neg;
    ralu_pkg::out_t y;
    an = {{32{x.a_num[ralu_pkg::NUM_W-1]}}, x.a_num};
    bn = {{32{x.b_num[ralu_pkg::NUM_W-1]}}, x.b_num};
    ad = {33'b0, x.a_den};
    bd = {33'b0, x.b_den};
    case (x.action)
      ralu_pkg::ACT_ADD: begin
        top = an * bd + ad * bn;
        bot = ad * bd;
      end
      ralu_pkg::ACT_SUB: begin
        top = an * bd - ad * bn;
        bot = ad * bd;
      end
      ralu_pkg::ACT_MUL: begin
        top = an * bn;
        bot = ad * bd;
      end
      default: begin
        top = an * bd;
        bot = ad * bn;
      end
    endcase
    y = '0;
    if (bot == 0) begin
      y.status = ralu_pkg::ST_DIV0;
      return y;
    end
    top_neg = top < 0;
    bot_neg = bot < 0;
    n = top_neg ? 64'(-top) : 64'(top);
    d = bot_neg ? 64'(-bot) : 64'(bot);
    g = n;
    r = d;
    while (r != 0) begin
      lim = g % r;
      g = r;
      r = lim;
    end
    n = n / g;
    d = d / g;
    neg = (top_neg != bot_neg) && n != 0;
    lim = 64'd1 << (ralu_pkg::WORD_BITS - 1);
    if (d > lim - 1 || (neg ? n > lim : n > lim - 1)) begin
      y.status = ralu_pkg::ST_OVF;
      return y;
    end
    y.res_num = neg ? -n[ralu_pkg::NUM_W-1:0] : n[ralu_pkg::NUM_W-1:0];
    y.res_den = d[ralu_pkg::DEN_W-1:0];
    y.status  = ralu_pkg::ST_OK;
    return y;
  endfunction

  function automatic ralu_pkg::in_t make_operands(logic [1:0] act, int an, int unsigned ad,
                                                  int bn, int unsigned bd);
    ralu_pkg::in_t x;
    x.action = act;
    x.a_num  = an;
    x.a_den  = ralu_pkg::DEN_W'(ad);
    x.b_num  = bn;
    x.b_den  = ralu_pkg::DEN_W'(bd);
    return x;
  endfunction

  function automatic logic signed [ralu_pkg::NUM_W-1:0] pick_numerator(int unsigned kind);
    int v;
    case (kind)
      0: v = int'($urandom_range(400)) - 200;
      1: v = int'($urandom_range(65535)) - 32768;
      2: v = $urandom;
      default: begin
        case ($urandom_range(5))
          0: v = 32'h8000_0000;
          1: v = 32'h8000_0001;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          default: v = 32'h7fff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [ralu_pkg::DEN_W-1:0] pick_denominator(int unsigned kind);
    logic [ralu_pkg::DEN_W-1:0] v;
    case (kind)
      0: v = ralu_pkg::DEN_W'(1 + $urandom_range(199));
      1: v = ralu_pkg::DEN_W'(1 + $urandom_range(65534));
      2: begin
        v = ralu_pkg::DEN_W'($urandom);
        if (v == 0) v = 1;
      end
      default: begin
        case ($urandom_range(4))
          0: v = 1;
          1: v = 2;
          2: v = 31'h4000_0000;
          3: v = 31'h7fff_fffe;
          default: v = 31'h7fff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  // Mostly small and medium fractions, so that reduction and the sign move are exercised
  // with results that fit; full-width and edge values mostly end in overflow.
  function automatic ralu_pkg::in_t random_operands();
    ralu_pkg::in_t x;
    int unsigned pick, kind, scale;
    pick = $urandom_range(99);
    kind = pick < 40 ? 0 : pick < 65 ? 1 : pick < 85 ? 2 : 3;
    x.action = 2'($urandom_range(3));
    x.a_num  = pick_numerator(kind);
    x.a_den  = pick_denominator(kind);
    if ($urandom_range(4) == 0) kind = $urandom_range(3);
    x.b_num = pick_numerator(kind);
    x.b_den = pick_denominator(kind);
    if (kind == 0 && $urandom_range(1) == 1) begin
      scale   = 2 + $urandom_range(998);
      x.b_num = x.b_num * scale;
      x.b_den = ralu_pkg::DEN_W'(x.b_den * scale);
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      x.b_num = x.a_num;
      x.b_den = x.a_den;
    end else if (pick < 8) begin
      x.b_num = 0;
    end else if (pick == 8) begin
      x.a_den = 0;
    end else if (pick == 9) begin
      x.b_den = 0;
    end
    return x;
  endfunction

  task automatic report_fault(input string what);
    faults++;
    if (faults <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_operands(input ralu_pkg::in_t item);
    while (tx_idle_en && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_fractions.push_back(reduce_fraction(item));
    @(negedge clk);
  endtask

  task automatic test_each_operation();
    offer_operands(make_operands(ralu_pkg::ACT_ADD, 1, 2, 1, 3));
    offer_operands(make_operands(ralu_pkg::ACT_SUB, 1, 2, 1, 3));
    offer_operands(make_operands(ralu_pkg::ACT_MUL, 2, 3, 3, 4));
    offer_operands(make_operands(ralu_pkg::ACT_DIV, 1, 2, 1, 4));
    offer_operands(make_operands(ralu_pkg::ACT_SUB, 3, 7, 3, 7));
    offer_operands(make_operands(ralu_pkg::ACT_MUL, 0, 5, -3, 4));
    offer_operands(make_operands(ralu_pkg::ACT_DIV, -1, 2, -1, 3));
    offer_operands(make_operands(ralu_pkg::ACT_DIV, 1, 2, -1, 3));
  endtask

  task automatic test_special_cases();
    // Division by a zero numerator, and zero denominators on either side.
    offer_operands(make_operands(ralu_pkg::ACT_DIV, 5, 3, 0, 7));
    offer_operands(make_operands(ralu_pkg::ACT_ADD, 1, 0, 1, 3));
    offer_operands(make_operands(ralu_pkg::ACT_MUL, 1, 3, 2, 0));
    // Numerators just past and just inside the word range.
    offer_operands(make_operands(ralu_pkg::ACT_ADD, 32'h7fff_ffff, 1, 1, 1));
    offer_operands(make_operands(ralu_pkg::ACT_MUL, 32'h8000_0000, 1, 1, 1));
    offer_operands(make_operands(ralu_pkg::ACT_MUL, 32'h8000_0000, 1, -1, 1));
    offer_operands(make_operands(ralu_pkg::ACT_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1));
    offer_operands(make_operands(ralu_pkg::ACT_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
    // Denominators at and beyond the limit.
    offer_operands(make_operands(ralu_pkg::ACT_DIV, 1, 31'h7fff_ffff, 2, 1));
    offer_operands(make_operands(ralu_pkg::ACT_MUL, 1, 31'h7fff_ffff, 32'h7fff_ffff, 1));
    offer_operands(make_operands(ralu_pkg::ACT_ADD, 32'h7fff_ffff, 31'h7fff_ffff,
                                 32'h8000_0000, 31'h7fff_ffff));
    offer_operands(make_operands(ralu_pkg::ACT_DIV, 32'h8000_0000, 1, 32'h7fff_ffff, 1));
    offer_operands(make_operands(ralu_pkg::ACT_ADD, -1, 31'h7fff_ffff, -1, 31'h7fff_ffff));
    offer_operands(make_operands(ralu_pkg::ACT_DIV, -1, 1, 32'h8000_0000, 1));
  endtask

  // The receiver holds off while items keep coming, so the block fills and drops in_ready.
  task automatic test_output_stall();
    hold_requests++;
    repeat (12) offer_operands(random_operands());
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_idle_en = !(i >= 500 && i < 800);
      rx_idle_en = tx_idle_en;
      offer_operands(random_operands());
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(rx_idle_en && $urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk) begin : check_results
    ralu_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_fractions.size() == 0) begin
        report_fault($sformatf("unexpected result %0d/%0d status %0d",
                               $signed(out_data.res_num), out_data.res_den,
                               out_data.status));
      end else begin
        want = expected_fractions.pop_front();
        if (out_data.res_num !== want.res_num || out_data.res_den !== want.res_den ||
            out_data.status !== want.status) begin
          report_fault($sformatf("expected %0d/%0d status %0d, got %0d/%0d status %0d",
                                 $signed(want.res_num), want.res_den, want.status,
                                 $signed(out_data.res_num), out_data.res_den,
                                 out_data.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    hold_requests = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_each_operation();
    test_special_cases();
    test_output_stall();
    test_random_mix();
    in_valid <= 1'b0;

    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ralu_pkg.sv
hdl/ralu_div.sv
hdl/rational_alu_with_reduction.sv
sim/tb_top.sv
